// ===== sv/qphs_pkg.sv =====
package qphs_pkg;

    // table geometry
    localparam int TABLE_SLOTS   = 16;
    localparam int SLOT_W        = $clog2(TABLE_SLOTS);
    localparam int SLOT_SUM_W    = SLOT_W + 1;
    localparam int KEY_W         = 31;
    localparam int SLOT_FIELD_W  = 4;

    localparam logic [SLOT_SUM_W-1:0] SLOTS_SUM = SLOT_SUM_W'(TABLE_SLOTS);
    localparam logic [SLOT_SUM_W-1:0] ODD_STEP  = SLOT_SUM_W'(2);
    localparam logic [SLOT_W-1:0]     ODD_FIRST = SLOT_W'(1);
    localparam logic [SLOT_W-1:0]     LAST_STEP = SLOT_W'(TABLE_SLOTS - 1);

    // request codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_DELETE = 2'd1;
    localparam logic [1:0] REQ_SEARCH = 2'd2;

    // result status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic                    status;
        logic [SLOT_FIELD_W-1:0] slot;
    } rsp_t;

    typedef enum logic {
        STATE_IDLE,
        STATE_PROBE
    } state_t;

endpackage

// ===== sv/quadratic_probe_hash_set.sv =====
// channel | direction | handshake            | beat
// --------+-----------+----------------------+------------------------------
// req     | in        | req_valid/req_stall  | req_type, key
// rsp     | out       | rsp_valid/rsp_stall  | status, slot
//
// a request is captured in the idle state and then probes up to TABLE_SLOTS
// slots in the probe state; the shared probe adder and key compare visit one
// slot per cycle, and no new request is taken until the chain ends
// reset clears the used bits and the control state; stored keys are not reset
// a stalled result sits in the output register while the next request runs;
// a probe that finishes while that register is still full waits in place
module quadratic_probe_hash_set
    import qphs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    // sequencer
    state_t state_reg;
    state_t state_next;

    // request held for the whole probe chain
    logic [1:0]       op_reg;
    logic [KEY_W-1:0] key_reg;

    // probe position, odd increment (2i+1 mod slots) and probe count
    logic [SLOT_W-1:0] pos_reg;
    logic [SLOT_W-1:0] pos_next;
    logic [SLOT_W-1:0] odd_reg;
    logic [SLOT_W-1:0] odd_next;
    logic [SLOT_W-1:0] step_reg;
    logic [SLOT_W-1:0] step_next;

    // table storage
    logic [KEY_W-1:0]       slot_key_reg [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] slot_used_reg;

    // output register
    logic rsp_valid_reg;
    logic rsp_valid_next;
    rsp_t rsp_reg;
    rsp_t rsp_next;

    // probe decision
    logic              hit_used;
    logic              hit_match;
    logic              last_probe;
    logic              finish;
    logic              fin_status;
    logic              out_free;
    logic              finish_go;
    logic              key_we;
    logic              used_set;
    logic              used_clr;
    logic [SLOT_SUM_W-1:0] pos_sum;
    logic [SLOT_SUM_W-1:0] odd_sum;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != STATE_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // shared probe unit: one slot read and one key compare per cycle
    assign hit_used   = slot_used_reg[pos_reg];
    assign hit_match  = (slot_key_reg[pos_reg] == key_reg);
    assign last_probe = (step_reg == LAST_STEP);

    // next probe position (pos + odd) and next odd increment (odd + 2), each mod slots with one compare and subtract
    always_comb
    begin
        pos_sum = {1'b0, pos_reg} + {1'b0, odd_reg};
        if (pos_sum >= SLOTS_SUM)
        begin
            pos_sum = pos_sum - SLOTS_SUM;
        end
        odd_sum = {1'b0, odd_reg} + ODD_STEP;
        if (odd_sum >= SLOTS_SUM)
        begin
            odd_sum = odd_sum - SLOTS_SUM;
        end
    end

    // outputs of the sequencer: decide whether this probe ends the request
    always_comb
    begin
        finish     = 1'b0;
        fin_status = STATUS_FAIL;
        key_we     = 1'b0;
        used_set   = 1'b0;
        used_clr   = 1'b0;
        if (state_reg == STATE_PROBE)
        begin
            unique case (op_reg)
                REQ_INSERT:
                begin
                    if (!hit_used)
                    begin
                        // first free slot takes the key
                        finish     = 1'b1;
                        fin_status = STATUS_OK;
                        key_we     = 1'b1;
                        used_set   = 1'b1;
                    end
                    else if (last_probe)
                    begin
                        // table full along this chain
                        finish = 1'b1;
                    end
                end
                REQ_DELETE, REQ_SEARCH:
                begin
                    if (!hit_used)
                    begin
                        // free slot ends the chain, key absent
                        finish = 1'b1;
                    end
                    else if (hit_match)
                    begin
                        finish     = 1'b1;
                        fin_status = STATUS_OK;
                        used_clr   = (op_reg == REQ_DELETE);
                    end
                    else if (last_probe)
                    begin
                        finish = 1'b1;
                    end
                end
                default:
                begin
                    // unknown operation gives a failure beat at once
                    finish = 1'b1;
                end
            endcase
        end
    end

    assign finish_go = finish && out_free;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            STATE_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = STATE_PROBE;
                end
            end
            STATE_PROBE:
            begin
                if (finish_go)
                begin
                    state_next = STATE_IDLE;
                end
            end
            default:
            begin
                state_next = STATE_IDLE;
            end
        endcase
    end

    // probe datapath next values
    always_comb
    begin
        pos_next  = pos_reg;
        odd_next  = odd_reg;
        step_next = step_reg;
        if (state_reg == STATE_IDLE)
        begin
            pos_next  = SLOT_W'(req.key % TABLE_SLOTS);
            odd_next  = ODD_FIRST;
            step_next = '0;
        end
        else if (!finish)
        begin
            pos_next  = pos_sum[SLOT_W-1:0];
            odd_next  = odd_sum[SLOT_W-1:0];
            step_next = step_reg + SLOT_W'(1);
        end
    end

    // result beat
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (finish_go)
        begin
            rsp_valid_next  = 1'b1;
            rsp_next.status = fin_status;
            rsp_next.slot   = (fin_status == STATUS_OK) ? SLOT_FIELD_W'(pos_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_IDLE;
            rsp_valid_reg <= 1'b0;
            slot_used_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (finish_go && used_set)
            begin
                slot_used_reg[pos_reg] <= 1'b1;
            end
            else if (finish_go && used_clr)
            begin
                slot_used_reg[pos_reg] <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        odd_reg  <= odd_next;
        step_reg <= step_next;
        rsp_reg  <= rsp_next;
        if (state_reg == STATE_IDLE)
        begin
            op_reg  <= req.req_type;
            key_reg <= req.key;
        end
        if (finish_go && key_we)
        begin
            slot_key_reg[pos_reg] <= key_reg;
        end
    end

    // a new result beat only follows a probe cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(state_reg == STATE_PROBE))
        else $error("result beat without a probe");

    // a stored key marks its slot used on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (finish_go && used_set) |=> slot_used_reg[$past(pos_reg)])
        else $error("inserted slot not marked used");

    // failure beats carry slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == STATUS_FAIL) |-> (rsp.slot == '0))
        else $error("failure beat with nonzero slot");

    // a probe never runs past the last step without finishing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == STATE_PROBE && last_probe && !finish_go) |=>
            (state_reg == STATE_PROBE && last_probe))
        else $error("probe chain ran past the last slot");

endmodule

// ===== test/quadratic_probe_hash_set_tb.sv =====
// checks the open-addressed key set against a behavioral copy of its table
// request beats go in through a sender that can work in bursts, result beats are
// drained by a receiver with its own stall pattern, and each result beat is
// compared in order with the oldest predicted one
module quadratic_probe_hash_set_tb;
    import qphs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // request code the block must turn away
    localparam logic [1:0] REQ_INVALID = 2'd3;

    // a beat never waits this long, not even behind a full probe chain
    localparam int WATCHDOG_LIMIT = 2000;
    // settle time after the last result beat
    localparam int TAIL_CYCLES = 3 * TABLE_SLOTS;
    localparam int POOL_SIZE = 24;
    localparam int MAX_REPORTS = 10;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_PERIODIC
    } stall_mode_t;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // behavioral copy of the table
    logic [KEY_W-1:0] shadow_key [TABLE_SLOTS];
    logic shadow_used [TABLE_SLOTS];

    // result beats still owed by the block, oldest first
    rsp_t pending_rsp [$];

    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    stall_mode_t stall_mode = STALL_RANDOM;
    bit bursty = 1'b1;
    int burst_left = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int stall_phase = 0;

    quadratic_probe_hash_set u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // apply one request to the shadow table and give the result beat it owes
    function automatic rsp_t apply_to_shadow(req_t r);
        rsp_t res;
        int unsigned home;
        int unsigned s;
        res.status = STATUS_FAIL;
        res.slot = '0;
        home = r.key % TABLE_SLOTS;
        if (r.req_type == REQ_INSERT)
        begin
            // first free slot on the quadratic chain, no duplicate check
            for (int step = 0; step < TABLE_SLOTS; step++)
            begin
                s = (home + step * step) % TABLE_SLOTS;
                if (!shadow_used[s])
                begin
                    shadow_used[s] = 1'b1;
                    shadow_key[s] = r.key;
                    res.status = STATUS_OK;
                    res.slot = SLOT_FIELD_W'(s);
                    return res;
                end
            end
        end
        else if (r.req_type == REQ_DELETE || r.req_type == REQ_SEARCH)
        begin
            // a free slot ends the chain, deletes leave no tombstone
            for (int step = 0; step < TABLE_SLOTS; step++)
            begin
                s = (home + step * step) % TABLE_SLOTS;
                if (!shadow_used[s])
                    break;
                if (shadow_key[s] == r.key)
                begin
                    if (r.req_type == REQ_DELETE)
                        shadow_used[s] = 1'b0;
                    res.status = STATUS_OK;
                    res.slot = SLOT_FIELD_W'(s);
                    return res;
                end
            end
        end
        return res;
    endfunction

    function automatic int slots_in_use();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_SLOTS; i++)
            if (shadow_used[i])
                n++;
        return n;
    endfunction

    // one request beat; in bursty mode a random gap opens once a burst runs out
    task automatic send_req(input logic [1:0] op, input logic [KEY_W-1:0] k);
        req_t beat;
        beat.req_type = op;
        beat.key = k;
        if (bursty && burst_left == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        req_valid <= 1'b1;
        req <= beat;
        do
            @(posedge clk);
        while (req_stall);
        pending_rsp.push_back(apply_to_shadow(beat));
        if (burst_left > 0)
            burst_left--;
    endtask

    // sender holds off until the block owes nothing
    task automatic wait_for_results();
        req_valid <= 1'b0;
        burst_left = 0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
    endtask

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: %s", $time, msg);
    endtask

    // half the pool shares a few home slots so chains collide and fill up
    task automatic refill_key_pool();
        logic [KEY_W-1:0] k;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            k = KEY_W'($urandom);
            if (i % 2 == 0)
                k = KEY_W'((k / TABLE_SLOTS) * TABLE_SLOTS + $urandom_range(0, 5));
            key_pool[i] = k;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
    endtask

    // random mix; inserts back off once five eighths of the table is in use, so
    // deletes and hits on stored keys stay common
    task automatic random_traffic(input int count);
        logic [1:0] op;
        logic [KEY_W-1:0] k;
        int pick;
        int grow;
        refill_key_pool();
        for (int n = 0; n < count; n++)
        begin
            grow = (slots_in_use() < TABLE_SLOTS * 5 / 8) ? 45 : 20;
            pick = $urandom_range(0, 99);
            if (pick < 4)
                op = REQ_INVALID;
            else if (pick < 4 + grow)
                op = REQ_INSERT;
            else if (pick[0])
                op = REQ_DELETE;
            else
                op = REQ_SEARCH;
            if ($urandom_range(0, 99) < 85)
                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                k = KEY_W'($urandom);
            send_req(op, k);
        end
    endtask

    // lookups on an empty table, including the top key
    task automatic test_empty_lookups();
        send_req(REQ_SEARCH, '0);
        send_req(REQ_DELETE, '1);
    endtask

    // smallest and largest key, the largest lands in the last home slot
    task automatic test_key_extremes();
        send_req(REQ_INSERT, '0);
        send_req(REQ_INSERT, '1);
        send_req(REQ_SEARCH, '1);
        send_req(REQ_DELETE, '1);
        send_req(REQ_SEARCH, '1);
    endtask

    // unknown request code is turned away and changes nothing
    task automatic test_invalid_request();
        send_req(REQ_INVALID, '0);
        send_req(REQ_INVALID, '1);
    endtask

    // a second copy of a key goes further down the chain; once the first
    // copy is removed its free slot hides the second one
    task automatic test_duplicate_insert();
        send_req(REQ_INSERT, KEY_W'(5));
        send_req(REQ_INSERT, KEY_W'(5));
        send_req(REQ_SEARCH, KEY_W'(5));
        send_req(REQ_DELETE, KEY_W'(5));
        send_req(REQ_SEARCH, KEY_W'(5));
    endtask

    // one home slot filled until the chain is full, a miss that walks every
    // probe, then a hole in the middle of the chain
    task automatic test_full_chain();
        for (int j = 0; j < 5; j++)
            send_req(REQ_INSERT, KEY_W'(3 + j * TABLE_SLOTS));
        send_req(REQ_SEARCH, KEY_W'(3 + 5 * TABLE_SLOTS));
        send_req(REQ_DELETE, KEY_W'(3 + 2 * TABLE_SLOTS));
        send_req(REQ_SEARCH, KEY_W'(3 + 3 * TABLE_SLOTS));
    endtask

    // back to back beats with the receiver always ready
    task automatic test_streaming();
        bursty = 1'b0;
        stall_mode = STALL_NONE;
        random_traffic(200);
    endtask

    task automatic test_bursts();
        bursty = 1'b1;
        stall_mode = STALL_RANDOM;
        random_traffic(300);
    endtask

    // long receiver stalls hold a result in the output register while the next probe waits behind it
    task automatic test_long_stalls();
        bursty = 1'b1;
        stall_mode = STALL_PERIODIC;
        random_traffic(250);
    endtask

    task automatic test_mixed_pressure();
        bursty = 1'b1;
        stall_mode = STALL_RANDOM;
        random_traffic(200);
    endtask

    // receiver stall pattern
    always @(posedge clk)
    begin
        stall_phase <= (stall_phase + 1) % 23;
        case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 35);
            STALL_PERIODIC: rsp_stall <= (stall_phase < 9);
            default:        rsp_stall <= 1'b0;
        endcase
    end

    // result beat check, in order against the oldest prediction
    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_rsp.size() == 0)
                note_mismatch($sformatf("result beat with none pending: status %0d slot %0d",
                    rsp.status, rsp.slot));
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp.status !== want.status)
                    note_mismatch($sformatf("status: expected %0d, actual %0d",
                        want.status, rsp.status));
                if (rsp.slot !== want.slot)
                    note_mismatch($sformatf("slot: expected %0d, actual %0d",
                        want.slot, rsp.slot));
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        req_valid <= 1'b0;
        req <= '0;
        // shadow table starts empty, like the block after reset
        for (int i = 0; i < TABLE_SLOTS; i++)
            shadow_used[i] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        test_empty_lookups();
        test_key_extremes();
        test_invalid_request();
        test_duplicate_insert();
        test_full_chain();
        wait_for_results();

        // random part
        test_streaming();
        test_bursts();
        // full drain before the stall-heavy phase
        wait_for_results();
        test_long_stalls();
        test_mixed_pressure();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
sv/qphs_pkg.sv
sv/quadratic_probe_hash_set.sv
test/quadratic_probe_hash_set_tb.sv
